// ===== hw/rtl/fba_pkg.sv =====
`default_nettype none

package fba_pkg;

   localparam int LEN_W  = 16;
   localparam int IDX_W  = 10;
   localparam int USED_W = 11;
   localparam int STAT_W = 2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_DISK_FULL = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd3;

   typedef enum logic {
      FSM_IDLE,
      FSM_POP
   } fsm_state_type;

   typedef struct packed {
      logic             kind;
      logic [LEN_W-1:0] byte_length;
      logic [IDX_W-1:0] block_index;
   } req_word_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              has_block;
      logic [IDX_W-1:0]  block_out;
      logic [USED_W-1:0] used_blocks;
      logic              last;
   } rsp_word_type;

   // Result of one pass through the shared length unit.
   typedef struct packed {
      logic             more;
      logic [LEN_W-1:0] rem_next;
   } len_step_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fba_ram.sv =====
`default_nettype none

module fba_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fba_len_unit.sv =====
`default_nettype none

module fba_len_unit #(
   parameter int BYTES_PER_BLOCK = 512
) (
   input  wire logic [fba_pkg::LEN_W-1:0] rem,
   output fba_pkg::len_step_type          step
);

   localparam int CMP_W = fba_pkg::LEN_W + 1;
   localparam logic [CMP_W-1:0] BLOCK_BYTES = CMP_W'(BYTES_PER_BLOCK);

   logic [CMP_W-1:0] rem_wide;
   logic [CMP_W-1:0] diff;

   // One block's worth of bytes is taken off per popped block; the word is
   // the last of its run once no more than one block of bytes remains.
   assign rem_wide      = {1'b0, rem};
   assign diff          = rem_wide - BLOCK_BYTES;
   assign step.more     = rem_wide > BLOCK_BYTES;
   assign step.rem_next = step.more ? diff[fba_pkg::LEN_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/free_block_list_allocator_unit.sv =====
`default_nettype none

// Block allocator over a first-in first-out ring of free block indices.
// Request channel: a word on req_data is taken at a rising edge where start
// is high and busy is low. A free word pushes block_index at the ring tail,
// unless the ring is full, and yields one result; an allocate word yields
// one result per popped block, or one result for a zero length, a run that
// is too large, and a disk-full stop after the blocks popped so far.
// Result channel: each result word sits on rsp_data for one cycle with
// rsp_valid high; the receiver cannot stall, so nothing is held back.
// Timing: a free, zero-length or refused word gives its result the cycle
// after it is taken; an allocate run pops its first block in FSM_POP.
// Throughput: free, zero-length and refused allocate words may follow each
// other back to back. An allocate run keeps busy high while it pops, one
// ring read and one result per cycle, set by the single read port of the
// ring memory and the shared length unit; no new word is taken until the
// run is over.
// Reset: the ring reads as indices 0 to TOTAL_BLOCKS-1 right away with no
// clearing pass; entries not yet written since reset read as their own
// index, tracked by the tail position and a wrap flag.

module free_block_list_allocator_unit #(
   parameter int TOTAL_BLOCKS    = 1024,
   parameter int BYTES_PER_BLOCK = 512,
   parameter int MAX_RUN         = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire fba_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   output fba_pkg::rsp_word_type      rsp_data
);

   localparam int PW = $clog2(TOTAL_BLOCKS);
   localparam int CW = $clog2(TOTAL_BLOCKS + 1);
   localparam logic [PW-1:0] LAST_PTR   = PW'(TOTAL_BLOCKS - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TOTAL_BLOCKS);
   localparam logic [31:0]   RUN_BYTES  = 32'(MAX_RUN * BYTES_PER_BLOCK);

   fba_pkg::fsm_state_type state_ff, state_in;
   logic [PW-1:0]               head_ff, head_in;
   logic [PW-1:0]               tail_ff, tail_in;
   logic                        wrapped_ff, wrapped_in;
   logic [CW-1:0]               free_cnt_ff, free_cnt_in;
   logic [CW-1:0]               used_cnt_ff, used_cnt_in;
   logic [fba_pkg::LEN_W-1:0]   rem_ff, rem_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   fba_pkg::rsp_word_type       rsp_data_ff, rsp_data_in;

   logic                        wr_en;
   logic [fba_pkg::IDX_W-1:0]   rd_data;
   fba_pkg::len_step_type       step;

   logic [PW-1:0]               head_step;
   logic [PW-1:0]               tail_step;
   logic [CW-1:0]               used_inc;
   logic [CW-1:0]               used_dec;
   logic [CW+fba_pkg::USED_W-1:0]  used_inc_wide;
   logic [CW+fba_pkg::USED_W-1:0]  used_dec_wide;
   logic [CW+fba_pkg::USED_W-1:0]  used_cur_wide;
   logic [PW+fba_pkg::IDX_W-1:0]   head_wide;
   logic                        entry_written;
   logic [fba_pkg::IDX_W-1:0]   pop_block;
   logic                        len_too_large;

   assign head_step = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign tail_step = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
   assign used_inc  = used_cnt_ff + 1'b1;
   assign used_dec  = (used_cnt_ff != '0) ? used_cnt_ff - 1'b1 : '0;

   assign used_inc_wide = {{fba_pkg::USED_W{1'b0}}, used_inc};
   assign used_dec_wide = {{fba_pkg::USED_W{1'b0}}, used_dec};
   assign used_cur_wide = {{fba_pkg::USED_W{1'b0}}, used_cnt_ff};
   assign head_wide     = {{fba_pkg::IDX_W{1'b0}}, head_ff};

   // Slots are written in order from zero, so a slot at or past the tail
   // still holds its reset index until the tail has wrapped once.
   assign entry_written = wrapped_ff || (head_ff < tail_ff);
   assign pop_block     = entry_written ? rd_data : head_wide[fba_pkg::IDX_W-1:0];
   assign len_too_large = {16'b0, req_data.byte_length} > RUN_BYTES;

   fba_len_unit #(
      .BYTES_PER_BLOCK(BYTES_PER_BLOCK)
   ) u_len_unit (
      .rem  (rem_ff),
      .step (step)
   );

   // The read address follows the next head, so the word at the head is
   // already registered whenever the sequencer pops.
   fba_ram #(
      .WIDTH(fba_pkg::IDX_W),
      .DEPTH(TOTAL_BLOCKS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_data.block_index),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fba_pkg::FSM_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         wrapped_ff   <= 1'b0;
         free_cnt_ff  <= FULL_COUNT;
         used_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wrapped_ff   <= wrapped_in;
         free_cnt_ff  <= free_cnt_in;
         used_cnt_ff  <= used_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      wrapped_in   = wrapped_ff;
      free_cnt_in  = free_cnt_ff;
      used_cnt_in  = used_cnt_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;

      case (state_ff)
         fba_pkg::FSM_IDLE: begin
            if (start) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = fba_pkg::STATUS_OK;
               rsp_data_in.has_block = 1'b0;
               rsp_data_in.block_out = '0;
               rsp_data_in.used_blocks = used_cur_wide[fba_pkg::USED_W-1:0];
               rsp_data_in.last      = 1'b1;
               if (req_data.kind == fba_pkg::KIND_FREE) begin
                  if (free_cnt_ff == FULL_COUNT) begin
                     rsp_data_in.status = fba_pkg::STATUS_OVERFLOW;
                  end else begin
                     wr_en       = 1'b1;
                     tail_in     = tail_step;
                     wrapped_in  = wrapped_ff || (tail_ff == LAST_PTR);
                     free_cnt_in = free_cnt_ff + 1'b1;
                     used_cnt_in = used_dec;
                     rsp_data_in.used_blocks = used_dec_wide[fba_pkg::USED_W-1:0];
                  end
               end else if (len_too_large) begin
                  rsp_data_in.status = fba_pkg::STATUS_TOO_LARGE;
               end else if (req_data.byte_length != '0) begin
                  rsp_valid_in = 1'b0;
                  rem_in       = req_data.byte_length;
                  state_in     = fba_pkg::FSM_POP;
               end
            end
         end
         fba_pkg::FSM_POP: begin
            rsp_valid_in = 1'b1;
            if (free_cnt_ff == '0) begin
               rsp_data_in.status      = fba_pkg::STATUS_DISK_FULL;
               rsp_data_in.has_block   = 1'b0;
               rsp_data_in.block_out   = '0;
               rsp_data_in.used_blocks = used_cur_wide[fba_pkg::USED_W-1:0];
               rsp_data_in.last        = 1'b1;
               state_in                = fba_pkg::FSM_IDLE;
            end else begin
               head_in                 = head_step;
               free_cnt_in             = free_cnt_ff - 1'b1;
               used_cnt_in             = used_inc;
               rem_in                  = step.rem_next;
               rsp_data_in.status      = fba_pkg::STATUS_OK;
               rsp_data_in.has_block   = 1'b1;
               rsp_data_in.block_out   = pop_block;
               rsp_data_in.used_blocks = used_inc_wide[fba_pkg::USED_W-1:0];
               rsp_data_in.last        = !step.more;
               if (!step.more) begin
                  state_in = fba_pkg::FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = fba_pkg::FSM_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != fba_pkg::FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== test/tb_free_block_list_allocator_unit.sv =====
module tb_free_block_list_allocator_unit;

   localparam int TOTAL_BLOCKS    = 1024;
   localparam int BYTES_PER_BLOCK = 512;
   localparam int MAX_RUN         = 20;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int LEN_W           = fba_pkg::LEN_W;
   localparam int IDX_W           = fba_pkg::IDX_W;
   localparam int USED_W          = fba_pkg::USED_W;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   fba_pkg::req_word_type req_data = '0;
   logic                  busy;
   logic                  rsp_valid;
   fba_pkg::rsp_word_type rsp_data;

   // Shadow copy of the allocator state, updated as each word is accepted.
   logic [IDX_W-1:0] shadow_ring [TOTAL_BLOCKS];
   logic [IDX_W-1:0] pop_ptr;
   logic [IDX_W-1:0] push_ptr;
   int               free_left;
   int               used_now;

   fba_pkg::rsp_word_type expected_results [$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           gaps_on = 1'b1;

   free_block_list_allocator_unit #(
      .TOTAL_BLOCKS(TOTAL_BLOCKS),
      .BYTES_PER_BLOCK(BYTES_PER_BLOCK),
      .MAX_RUN(MAX_RUN)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_free_block_list_allocator_unit: FAIL");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Each result word is compared with the oldest word still owed.
   always @(posedge clock) begin
      fba_pkg::rsp_word_type owed;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result word %h", rsp_data));
         end else begin
            owed = expected_results.pop_front();
            if (rsp_data.status !== owed.status)
               report($sformatf("status %0d, wanted %0d", rsp_data.status, owed.status));
            if (rsp_data.has_block !== owed.has_block)
               report($sformatf("has_block %0d, wanted %0d", rsp_data.has_block,
                                owed.has_block));
            if (rsp_data.block_out !== owed.block_out)
               report($sformatf("block_out %0d, wanted %0d", rsp_data.block_out,
                                owed.block_out));
            if (rsp_data.used_blocks !== owed.used_blocks)
               report($sformatf("used_blocks %0d, wanted %0d", rsp_data.used_blocks,
                                owed.used_blocks));
            if (rsp_data.last !== owed.last)
               report($sformatf("last %0d, wanted %0d", rsp_data.last, owed.last));
         end
      end
   end

   task automatic reset_shadow();
      for (int i = 0; i < TOTAL_BLOCKS; i++) shadow_ring[i] = IDX_W'(i);
      pop_ptr   = '0;
      push_ptr  = '0;
      free_left = TOTAL_BLOCKS;
      used_now  = 0;
   endtask

   // Works out the result words that one accepted request word causes.
   task automatic predict_words(input fba_pkg::req_word_type w);
      fba_pkg::rsp_word_type r;
      int           blocks_needed;
      r = '0;
      r.last = 1'b1;
      if (w.kind == fba_pkg::KIND_FREE) begin
         if (free_left >= TOTAL_BLOCKS) begin
            r.status = fba_pkg::STATUS_OVERFLOW;
         end else begin
            shadow_ring[push_ptr] = w.block_index;
            push_ptr = push_ptr + 1'b1;
            free_left++;
            if (used_now > 0) used_now--;
            r.status = fba_pkg::STATUS_OK;
         end
         r.used_blocks = USED_W'(used_now);
         expected_results.push_back(r);
         return;
      end
      blocks_needed = (int'(w.byte_length) + BYTES_PER_BLOCK - 1) / BYTES_PER_BLOCK;
      if (blocks_needed > MAX_RUN) begin
         r.status = fba_pkg::STATUS_TOO_LARGE;
         r.used_blocks = USED_W'(used_now);
         expected_results.push_back(r);
         return;
      end
      if (blocks_needed == 0) begin
         r.status = fba_pkg::STATUS_OK;
         r.used_blocks = USED_W'(used_now);
         expected_results.push_back(r);
         return;
      end
      for (int k = 0; k < blocks_needed; k++) begin
         r = '0;
         if (free_left == 0) begin
            // Blocks already handed out by this run stay used.
            r.status = fba_pkg::STATUS_DISK_FULL;
            r.last = 1'b1;
            r.used_blocks = USED_W'(used_now);
            expected_results.push_back(r);
            return;
         end
         r.status = fba_pkg::STATUS_OK;
         r.has_block = 1'b1;
         r.block_out = shadow_ring[pop_ptr];
         pop_ptr = pop_ptr + 1'b1;
         free_left--;
         used_now++;
         r.used_blocks = USED_W'(used_now);
         r.last = (k == blocks_needed - 1);
         expected_results.push_back(r);
      end
   endtask

   // Start stays high after acceptance so back-to-back words need no toggle.
   task automatic send_word(input logic kind, input logic [LEN_W-1:0] len,
                            input logic [IDX_W-1:0] idx);
      fba_pkg::req_word_type w;
      w.kind = kind;
      w.byte_length = len;
      w.block_index = idx;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_words(w);
   endtask

   task automatic alloc_bytes(input int len);
      send_word(fba_pkg::KIND_ALLOC, LEN_W'(len), IDX_W'($urandom));
   endtask

   task automatic free_block(input int idx);
      send_word(fba_pkg::KIND_FREE, LEN_W'($urandom), IDX_W'(idx));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic int random_length();
      if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535));
      return int'($urandom_range(0, MAX_RUN * BYTES_PER_BLOCK));
   endfunction

   // Right after reset the ring is full, so frees must be refused.
   task automatic test_full_ring_after_reset();
      free_block(0);
      free_block(TOTAL_BLOCKS - 1);
      alloc_bytes(0);
   endtask

   task automatic test_length_edges();
      alloc_bytes(1);
      alloc_bytes(BYTES_PER_BLOCK - 1);
      alloc_bytes(BYTES_PER_BLOCK);
      alloc_bytes(BYTES_PER_BLOCK + 1);
      alloc_bytes(MAX_RUN * BYTES_PER_BLOCK - 1);
      alloc_bytes(MAX_RUN * BYTES_PER_BLOCK);
      alloc_bytes(MAX_RUN * BYTES_PER_BLOCK + 1);
      alloc_bytes(16384);
      alloc_bytes(32768);
      alloc_bytes(65535);
      alloc_bytes(0);
      free_block(0);
      free_block(TOTAL_BLOCKS - 1);
      free_block('h155);
      free_block('h2AA);
      free_block('h2AA);
   endtask

   // Allocates long runs until the disk runs out, ending with a run cut short.
   task automatic test_drain_to_disk_full();
      while (free_left > 0)
         alloc_bytes($urandom_range((MAX_RUN - 4) * BYTES_PER_BLOCK + 1,
                                    MAX_RUN * BYTES_PER_BLOCK));
      alloc_bytes(MAX_RUN * BYTES_PER_BLOCK);
      alloc_bytes($urandom_range(1, MAX_RUN * BYTES_PER_BLOCK));
   endtask

   // Returns a handful of blocks so later runs pop slots written by frees.
   task automatic test_partial_refill();
      repeat (15) free_block($urandom_range(0, TOTAL_BLOCKS - 1));
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 15; i++) begin
         gaps_on = (i < 10);
         if ($urandom_range(0, 9) < 4) free_block($urandom_range(0, TOTAL_BLOCKS - 1));
         else alloc_bytes(random_length());
      end
   endtask

   initial begin
      reset_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_ring_after_reset();
      test_length_edges();
      wait_drained();
      test_drain_to_disk_full();
      wait_drained();
      test_partial_refill();
      test_random_mix();
      wait_drained();
      repeat (2 * MAX_RUN + 5) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_free_block_list_allocator_unit: PASS");
      end else begin
         $display("tb_free_block_list_allocator_unit: FAIL");
      end
      $finish;
   end

endmodule
